[src/lru_ts_pkg.sv]
`timescale 1ns / 1ps

package lru_ts_pkg;

    localparam int PAGE_W  = 16;
    localparam int STAMP_W = 32;
    localparam int CFG_W   = 4;

    localparam logic [STAMP_W-1:0] STAMP_MAX = '1;

    typedef enum logic [3:0] {
        S_IDLE  = 4'b0001,
        S_SCAN  = 4'b0010,
        S_WRITE = 4'b0100,
        S_HOLD  = 4'b1000
    } t_state;

endpackage

[src/lru_timestamp_page_replacer_core.sv]
`timescale 1ns / 1ps

// LRU page replacer with per-frame last-use timestamps.
// Slave stream: one beat per page reference; tdata carries the page number,
// tuser the restart flag, which clears frames, time and fault count first.
// Master stream: one beat per reference with hit/evicted flags in tuser and
// evicted page, evicted stamp, access stamp and fault total in tdata.
// Config channel: frame limit; the user must write it only while the block is idle (not enforced).
// Each reference goes from accept through a scan state and an update state
// back to idle. The scan walks the page and stamp memories frame by frame
// through a single compare unit for the hit, the first free frame and the
// oldest stamp; the update state then writes the chosen frame and loads the
// result register. s_axis_tready is high only while idle.
// A stalled master side holds the result; a finished next item then waits in
// its update cycle until the output register is free.
// Reset empties all frames, clears time and fault count and sets the frame
// limit to NUM_FRAMES. No clearing pass is needed.
module lru_timestamp_page_replacer_core #(
    parameter int NUM_FRAMES = 8,
    parameter int PAGE_BITS  = 16
) (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   i_cfg_valid,
    output logic                                   o_cfg_ready,
    input  logic [lru_ts_pkg::CFG_W-1:0]           i_cfg_data,   // frame_limit
    input  logic                                   s_axis_tvalid,
    output logic                                   s_axis_tready,
    input  logic [lru_ts_pkg::PAGE_W-1:0]          s_axis_tdata, // page
    input  logic                                   s_axis_tuser, // restart
    output logic                                   m_axis_tvalid,
    input  logic                                   m_axis_tready,
    // evicted_page, evicted_last_use, access_stamp, fault_total
    output logic [lru_ts_pkg::PAGE_W+3*lru_ts_pkg::STAMP_W-1:0] m_axis_tdata,
    output logic [1:0]                             m_axis_tuser  // hit, evicted
);
    import lru_ts_pkg::*;

    localparam int PW   = (PAGE_BITS < PAGE_W) ? PAGE_BITS : PAGE_W;
    localparam int IW   = (NUM_FRAMES > 1) ? $clog2(NUM_FRAMES) : 1;
    localparam int OW   = $clog2(NUM_FRAMES + 1);
    localparam int LW   = (OW > CFG_W) ? OW : CFG_W;
    localparam logic [IW-1:0] LAST_IDX = IW'(NUM_FRAMES - 1);
    localparam logic [LW-1:0] LIM_MAX  = LW'(NUM_FRAMES);

    logic [PW-1:0]      mem_pg [NUM_FRAMES];
    logic [STAMP_W-1:0] mem_st [NUM_FRAMES];

    t_state              r_state, n_state;
    logic [NUM_FRAMES-1:0] r_valid, n_valid;
    logic [OW-1:0]       r_occ, n_occ;
    logic [STAMP_W-1:0]  r_time, n_time;
    logic [STAMP_W-1:0]  r_fault, n_fault;
    logic [LW-1:0]       r_limit;
    logic                r_out_valid, n_out_valid;

    logic [IW-1:0]       r_idx, n_idx;
    logic [PW-1:0]       r_page, n_page;
    logic                r_hit, n_hit;
    logic [IW-1:0]       r_hit_idx, n_hit_idx;
    logic                r_free_ok, n_free_ok;
    logic [IW-1:0]       r_free_idx, n_free_idx;
    logic                r_old_ok, n_old_ok;
    logic [IW-1:0]       r_old_idx, n_old_idx;
    logic [STAMP_W-1:0]  r_old_st, n_old_st;
    logic [PW-1:0]       r_old_pg, n_old_pg;

    logic [PW-1:0]       r_pg_q;
    logic [STAMP_W-1:0]  r_st_q;
    logic [IW-1:0]       rd_addr;

    logic                wr_en;
    logic [IW-1:0]       wr_slot;

    logic                r_o_hit, n_o_hit;
    logic                r_o_ev, n_o_ev;
    logic [PW-1:0]       r_o_ev_pg, n_o_ev_pg;
    logic [STAMP_W-1:0]  r_o_ev_st, n_o_ev_st;
    logic [STAMP_W-1:0]  r_o_stamp, n_o_stamp;
    logic [STAMP_W-1:0]  r_o_fault, n_o_fault;

    logic [LW-1:0]       act_limit;
    logic [STAMP_W-1:0]  base_time;
    logic                vld_i;

    assign o_cfg_ready   = 1'b1;
    assign s_axis_tready = (r_state == S_IDLE);
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tuser  = {r_o_ev, r_o_hit};
    assign m_axis_tdata  = {r_o_fault, r_o_stamp, r_o_ev_st, PAGE_W'(r_o_ev_pg)};

    always_comb begin
        if (r_limit == '0) begin
            act_limit = LW'(1);
        end else if (r_limit > LIM_MAX) begin
            act_limit = LIM_MAX;
        end else begin
            act_limit = r_limit;
        end
    end

    always_comb begin
        if (r_state == S_SCAN && r_idx != LAST_IDX) begin
            rd_addr = r_idx + IW'(1);
        end else begin
            rd_addr = '0;
        end
    end

    assign vld_i     = r_valid[r_idx];
    assign base_time = s_axis_tuser ? '0 : r_time;

    always_comb begin
        n_state     = r_state;
        n_valid     = r_valid;
        n_occ       = r_occ;
        n_time      = r_time;
        n_fault     = r_fault;
        n_out_valid = r_out_valid;
        n_idx       = r_idx;
        n_page      = r_page;
        n_hit       = r_hit;
        n_hit_idx   = r_hit_idx;
        n_free_ok   = r_free_ok;
        n_free_idx  = r_free_idx;
        n_old_ok    = r_old_ok;
        n_old_idx   = r_old_idx;
        n_old_st    = r_old_st;
        n_old_pg    = r_old_pg;
        n_o_hit     = r_o_hit;
        n_o_ev      = r_o_ev;
        n_o_ev_pg   = r_o_ev_pg;
        n_o_ev_st   = r_o_ev_st;
        n_o_stamp   = r_o_stamp;
        n_o_fault   = r_o_fault;
        wr_en       = 1'b0;
        wr_slot     = '0;

        if (r_out_valid && m_axis_tready) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            S_IDLE: begin
                if (s_axis_tvalid) begin
                    if (s_axis_tuser) begin
                        n_valid = '0;
                        n_occ   = '0;
                        n_fault = '0;
                    end
                    n_time    = (base_time == STAMP_MAX) ? base_time : base_time + 1'b1;
                    n_page    = s_axis_tdata[PW-1:0];
                    n_idx     = '0;
                    n_hit     = 1'b0;
                    n_free_ok = 1'b0;
                    n_old_ok  = 1'b0;
                    n_state   = S_SCAN;
                end
            end
            S_SCAN: begin
                if (vld_i && r_pg_q == r_page && !r_hit) begin
                    n_hit     = 1'b1;
                    n_hit_idx = r_idx;
                end
                if (!vld_i && !r_free_ok) begin
                    n_free_ok  = 1'b1;
                    n_free_idx = r_idx;
                end
                if (vld_i && (!r_old_ok || r_st_q < r_old_st)) begin
                    n_old_ok  = 1'b1;
                    n_old_idx = r_idx;
                    n_old_st  = r_st_q;
                    n_old_pg  = r_pg_q;
                end
                if (r_idx == LAST_IDX) begin
                    n_state = S_WRITE;
                end else begin
                    n_idx = r_idx + IW'(1);
                end
            end
            S_WRITE: begin
                if (!r_out_valid || m_axis_tready) begin
                    wr_en     = 1'b1;
                    n_o_hit   = r_hit;
                    n_o_ev    = 1'b0;
                    n_o_ev_pg = '0;
                    n_o_ev_st = '0;
                    n_o_stamp = r_time;
                    n_o_fault = r_fault;
                    if (r_hit) begin
                        wr_slot = r_hit_idx;
                    end else begin
                        if (r_fault != STAMP_MAX) begin
                            n_fault   = r_fault + 1'b1;
                            n_o_fault = r_fault + 1'b1;
                        end
                        if (LW'(r_occ) < act_limit && r_free_ok) begin
                            wr_slot            = r_free_idx;
                            n_valid[r_free_idx] = 1'b1;
                            n_occ              = r_occ + OW'(1);
                        end else if (r_old_ok) begin
                            wr_slot   = r_old_idx;
                            n_o_ev    = 1'b1;
                            n_o_ev_pg = r_old_pg;
                            n_o_ev_st = r_old_st;
                        end else begin
                            wr_slot    = '0;
                            n_valid[0] = 1'b1;
                            n_occ      = OW'(1);
                        end
                    end
                    n_out_valid = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            S_HOLD: begin
                n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_pg_q <= mem_pg[rd_addr];
        r_st_q <= mem_st[rd_addr];
        if (wr_en) begin
            mem_pg[wr_slot] <= r_page;
            mem_st[wr_slot] <= r_time;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_valid     <= '0;
            r_occ       <= '0;
            r_time      <= '0;
            r_fault     <= '0;
            r_limit     <= LIM_MAX;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_valid     <= n_valid;
            r_occ       <= n_occ;
            r_time      <= n_time;
            r_fault     <= n_fault;
            r_out_valid <= n_out_valid;
            if (i_cfg_valid && o_cfg_ready) begin
                r_limit <= LW'(i_cfg_data);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_idx      <= n_idx;
        r_page     <= n_page;
        r_hit      <= n_hit;
        r_hit_idx  <= n_hit_idx;
        r_free_ok  <= n_free_ok;
        r_free_idx <= n_free_idx;
        r_old_ok   <= n_old_ok;
        r_old_idx  <= n_old_idx;
        r_old_st   <= n_old_st;
        r_old_pg   <= n_old_pg;
        r_o_hit    <= n_o_hit;
        r_o_ev     <= n_o_ev;
        r_o_ev_pg  <= n_o_ev_pg;
        r_o_ev_st  <= n_o_ev_st;
        r_o_stamp  <= n_o_stamp;
        r_o_fault  <= n_o_fault;
    end

endmodule
